// File: hw/rtl/vph_pkg.sv
// Shared types and constants of the vanishing-point hypothesis scorer.
// No dependencies; used by the controller, the datapath and the top level.
package vph_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_VP_X    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_VP_Y    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_VP_W    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_COS_THR = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MIN_LEN = 3'd4;

  // Product steps of one segment, in the order the sequencer issues them.
  typedef enum logic [4:0] {
    OP_UX     = 5'd0,
    OP_UY     = 5'd1,
    OP_A      = 5'd2,
    OP_B      = 5'd3,
    OP_C      = 5'd4,
    OP_D      = 5'd5,
    OP_DOT_X  = 5'd6,
    OP_DOT_Y  = 5'd7,
    OP_DU_X   = 5'd8,
    OP_DU_Y   = 5'd9,
    OP_DV_X   = 5'd10,
    OP_DV_Y   = 5'd11,
    OP_TDU    = 5'd12,
    OP_RHS    = 5'd13,
    OP_LHS    = 5'd14,
    OP_P1     = 5'd15,
    OP_P2     = 5'd16
  } op_e;

  // Index of the most significant 16-bit chunk of the B operand of a step.
  function automatic logic [1:0] op_last_chunk(op_e op);
    logic [1:0] r;
    case (op) inside
      OP_DV_X, OP_DV_Y, OP_P1, OP_P2: r = 2'd2;
      OP_RHS, OP_LHS:                 r = 2'd3;
      OP_TDU:                         r = 2'd0;
      default:                        r = 2'd1;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic       load;    // capture the input transaction
    logic       mul_en;  // run one multiply chunk
    logic       first;   // chunk starts a new product
    logic       store;   // write the finished product to its destination
    logic       finish;  // decide, update the score, fill the result register
    op_e        op;
    logic [1:0] chunk;
  } ctrl_cmd_t;

endpackage

// File: hw/rtl/vph_seg_if.sv
// Segment input channel: valid/ready handshake with the segment fields.
// Depends on nothing.
interface vph_seg_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic        [15:0] seg_length;
  logic               live;
  logic               last_in;

  modport source (output valid, start_x, start_y, end_x, end_y, seg_length, live, last_in,
                  input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, seg_length, live, last_in,
                  output ready);
endinterface

// File: hw/rtl/vph_res_if.sv
// Result output channel: valid/ready handshake with the result fields.
// Depends on nothing.
interface vph_res_if;
  logic        valid;
  logic        ready;
  logic        inlier;
  logic [31:0] score;
  logic        last_out;

  modport source (output valid, inlier, score, last_out, input ready);
  modport sink   (input valid, inlier, score, last_out, output ready);
endinterface

// File: hw/rtl/vph_ctrl.sv
// Sequencer of the scorer: walks the product steps chunk by chunk.
// Depends on vph_pkg.
module vph_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vph_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MUL    = 4'b0010,
    S_STORE  = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e         state_q, state_d;
  vph_pkg::op_e   op_q, op_d;
  logic [1:0]     chunk_q, chunk_d;
  logic           out_valid_q, out_valid_d;
  logic           can_finish;

  assign can_finish = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    chunk_d      = chunk_q;
    cmd_o        = '0;
    cmd_o.op     = op_q;
    cmd_o.chunk  = chunk_q;
    in_ready_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = vph_pkg::OP_UX;
          chunk_d    = vph_pkg::op_last_chunk(vph_pkg::OP_UX);
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.first  = (chunk_q == vph_pkg::op_last_chunk(op_q));
        if (chunk_q == 2'd0) begin
          state_d = S_STORE;
        end else begin
          chunk_d = chunk_q - 2'd1;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        if (op_q == vph_pkg::OP_P2) begin
          state_d = S_FINISH;
        end else begin
          op_d    = vph_pkg::op_e'(op_q + 5'd1);
          chunk_d = vph_pkg::op_last_chunk(vph_pkg::op_e'(op_q + 5'd1));
          state_d = S_MUL;
        end
      end
      S_FINISH: begin
        if (can_finish) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= vph_pkg::OP_UX;
      chunk_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      chunk_q     <= chunk_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.mul_en, cmd_o.store, cmd_o.finish}))
    else $error("controller issued two commands at once");

  a_finish_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("result register not filled after finish");

  a_chunk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (chunk_q <= vph_pkg::op_last_chunk(op_q)))
    else $error("chunk index beyond operand width");

  a_store_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STORE) |-> $past(state_q == S_MUL))
    else $error("store without a completed product");

endmodule

// File: hw/rtl/vph_datapath.sv
// Datapath of the scorer: configuration, operand registers, the shared
// 84x16 chunk multiplier with its accumulator, decision and score. Depends on vph_pkg.
module vph_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vph_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [vph_pkg::CfgDataW-1:0]  cfg_data_i,
  input  vph_pkg::ctrl_cmd_t            cmd_i,
  input  logic signed [15:0]            start_x_i,
  input  logic signed [15:0]            start_y_i,
  input  logic signed [15:0]            end_x_i,
  input  logic signed [15:0]            end_y_i,
  input  logic        [15:0]            seg_length_i,
  input  logic                          live_i,
  input  logic                          last_in_i,
  output logic                          inlier_o,
  output logic        [31:0]            score_o,
  output logic                          last_out_o
);

  // Configuration.
  logic signed [23:0] vp_x_q, vp_y_q, vp_w_q;
  logic [15:0]        thr_q, min_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_x_q    <= '0;
      vp_y_q    <= '0;
      vp_w_q    <= '0;
      thr_q     <= '0;
      min_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        vph_pkg::CFG_VP_X:    vp_x_q    <= cfg_data_i;
        vph_pkg::CFG_VP_Y:    vp_y_q    <= cfg_data_i;
        vph_pkg::CFG_VP_W:    vp_w_q    <= cfg_data_i;
        vph_pkg::CFG_COS_THR: thr_q     <= cfg_data_i[15:0];
        vph_pkg::CFG_MIN_LEN: min_len_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Segment registers and intermediate results.
  logic signed [15:0]  sx_q, sy_q, ex_q, ey_q;
  logic [15:0]         len_q;
  logic                live_q, last_q;
  logic signed [16:0]  dx_q, dy_q, smx_q, smy_q;
  logic signed [41:0]  vx_q, vy_q;
  logic signed [39:0]  a_q, b_q, c_q, d_q;
  logic signed [59:0]  dot_q;
  logic [32:0]         du_q;
  logic [82:0]         dv_q;
  logic [48:0]         tdu_q;
  logic [131:0]        rhs_q;
  logic [135:0]        lhs_q;
  logic [79:0]         p1_q, p2_q;
  logic [147:0]        acc_q, acc_d;
  logic [31:0]         score_q;

  // Magnitudes of the operands.
  logic [23:0] pw_m;
  logic [16:0] smx_m, smy_m, dx_m, dy_m;
  logic [15:0] sx_m, sy_m, ex_m, ey_m;
  logic [41:0] vx_m, vy_m;
  logic [59:0] dot_m;
  logic [39:0] a_m, b_m, c_m, d_m;

  assign pw_m  = vp_w_q[23] ? 24'(-vp_w_q) : vp_w_q;
  assign smx_m = smx_q[16] ? 17'(-smx_q) : smx_q;
  assign smy_m = smy_q[16] ? 17'(-smy_q) : smy_q;
  assign dx_m  = dx_q[16]  ? 17'(-dx_q)  : dx_q;
  assign dy_m  = dy_q[16]  ? 17'(-dy_q)  : dy_q;
  assign sx_m  = sx_q[15]  ? 16'(-sx_q)  : sx_q;
  assign sy_m  = sy_q[15]  ? 16'(-sy_q)  : sy_q;
  assign ex_m  = ex_q[15]  ? 16'(-ex_q)  : ex_q;
  assign ey_m  = ey_q[15]  ? 16'(-ey_q)  : ey_q;
  assign vx_m  = vx_q[41]  ? 42'(-vx_q)  : vx_q;
  assign vy_m  = vy_q[41]  ? 42'(-vy_q)  : vy_q;
  assign dot_m = dot_q[59] ? 60'(-dot_q) : dot_q;
  assign a_m   = a_q[39]   ? 40'(-a_q)   : a_q;
  assign b_m   = b_q[39]   ? 40'(-b_q)   : b_q;
  assign c_m   = c_q[39]   ? 40'(-c_q)   : c_q;
  assign d_m   = d_q[39]   ? 40'(-d_q)   : d_q;

  // Operand selection for the current step; sgn is the sign of the product.
  logic [83:0] opa;
  logic [63:0] opb;
  logic        sgn;

  always_comb begin
    opa = '0;
    opb = '0;
    sgn = 1'b0;
    case (cmd_i.op)
      vph_pkg::OP_UX:    begin opa = 84'(smx_m); opb = 64'(pw_m); sgn = smx_q[16] ^ vp_w_q[23]; end
      vph_pkg::OP_UY:    begin opa = 84'(smy_m); opb = 64'(pw_m); sgn = smy_q[16] ^ vp_w_q[23]; end
      vph_pkg::OP_A:     begin opa = 84'(sx_m);  opb = 64'(pw_m); sgn = sx_q[15] ^ vp_w_q[23]; end
      vph_pkg::OP_B:     begin opa = 84'(ex_m);  opb = 64'(pw_m); sgn = ex_q[15] ^ vp_w_q[23]; end
      vph_pkg::OP_C:     begin opa = 84'(sy_m);  opb = 64'(pw_m); sgn = sy_q[15] ^ vp_w_q[23]; end
      vph_pkg::OP_D:     begin opa = 84'(ey_m);  opb = 64'(pw_m); sgn = ey_q[15] ^ vp_w_q[23]; end
      vph_pkg::OP_DOT_X: begin opa = 84'(vx_m);  opb = 64'(dx_m); sgn = vx_q[41] ^ dx_q[16]; end
      vph_pkg::OP_DOT_Y: begin opa = 84'(vy_m);  opb = 64'(dy_m); sgn = vy_q[41] ^ dy_q[16]; end
      vph_pkg::OP_DU_X:  begin opa = 84'(dx_m);  opb = 64'(dx_m); end
      vph_pkg::OP_DU_Y:  begin opa = 84'(dy_m);  opb = 64'(dy_m); end
      vph_pkg::OP_DV_X:  begin opa = 84'(vx_m);  opb = 64'(vx_m); end
      vph_pkg::OP_DV_Y:  begin opa = 84'(vy_m);  opb = 64'(vy_m); end
      vph_pkg::OP_TDU:   begin opa = 84'(du_q);  opb = 64'(thr_q); end
      vph_pkg::OP_RHS:   begin opa = 84'(dv_q);  opb = 64'(tdu_q); end
      vph_pkg::OP_LHS:   begin opa = 84'(dot_m); opb = 64'(dot_m); end
      vph_pkg::OP_P1:    begin opa = 84'(a_m);   opb = 64'(b_m); end
      vph_pkg::OP_P2:    begin opa = 84'(c_m);   opb = 64'(d_m); end
      default: ;
    endcase
  end

  // Chunk multiplier, most significant chunk of B first.
  logic [15:0] b_chunk;
  logic [99:0] pp;

  assign b_chunk = opb[16*cmd_i.chunk +: 16];
  assign pp      = opa * b_chunk;

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.mul_en) begin
      acc_d = cmd_i.first ? 148'(pp) : {acc_q[131:0], 16'h0000} + 148'(pp);
    end
  end

  // Signed view of products that fit in 64 bits.
  logic signed [63:0] prod_s;
  assign prod_s = sgn ? -$signed(acc_q[63:0]) : $signed(acc_q[63:0]);

  // Decision.
  logic        n1, n2, angle_ok, between, inl;
  logic [80:0] neg, pos;
  logic [32:0] sum;
  logic [31:0] score_new;

  assign n1       = a_q[39] ^ b_q[39];
  assign n2       = c_q[39] ^ d_q[39];
  assign neg      = (n1 ? 81'(p1_q) : 81'd0) + (n2 ? 81'(p2_q) : 81'd0);
  assign pos      = (n1 ? 81'd0 : 81'(p1_q)) + (n2 ? 81'd0 : 81'(p2_q));
  assign angle_ok = lhs_q > 136'(rhs_q);
  assign between  = (vp_w_q != 24'sd0) && (neg > pos);
  assign inl      = live_q && (len_q >= min_len_q) && angle_ok && !between;
  assign sum      = {1'b0, score_q} + 33'(len_q);
  assign score_new = !inl ? score_q : (sum[32] ? 32'hFFFF_FFFF : sum[31:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q <= '0;
    end else if (cmd_i.finish) begin
      score_q <= last_q ? 32'd0 : score_new;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.load) begin
      sx_q   <= start_x_i;
      sy_q   <= start_y_i;
      ex_q   <= end_x_i;
      ey_q   <= end_y_i;
      len_q  <= seg_length_i;
      live_q <= live_i;
      last_q <= last_in_i;
      dx_q   <= 17'(start_x_i) - 17'(end_x_i);
      dy_q   <= 17'(start_y_i) - 17'(end_y_i);
      smx_q  <= 17'(start_x_i) + 17'(end_x_i);
      smy_q  <= 17'(start_y_i) + 17'(end_y_i);
    end
    if (cmd_i.store) begin
      case (cmd_i.op)
        vph_pkg::OP_UX:    vx_q  <= prod_s[41:0] - {{17{vp_x_q[23]}}, vp_x_q, 1'b0};
        vph_pkg::OP_UY:    vy_q  <= prod_s[41:0] - {{17{vp_y_q[23]}}, vp_y_q, 1'b0};
        vph_pkg::OP_A:     a_q   <= prod_s[39:0] - {{16{vp_x_q[23]}}, vp_x_q};
        vph_pkg::OP_B:     b_q   <= prod_s[39:0] - {{16{vp_x_q[23]}}, vp_x_q};
        vph_pkg::OP_C:     c_q   <= prod_s[39:0] - {{16{vp_y_q[23]}}, vp_y_q};
        vph_pkg::OP_D:     d_q   <= prod_s[39:0] - {{16{vp_y_q[23]}}, vp_y_q};
        vph_pkg::OP_DOT_X: dot_q <= prod_s[59:0];
        vph_pkg::OP_DOT_Y: dot_q <= dot_q + prod_s[59:0];
        vph_pkg::OP_DU_X:  du_q  <= acc_q[32:0];
        vph_pkg::OP_DU_Y:  du_q  <= du_q + acc_q[32:0];
        vph_pkg::OP_DV_X:  dv_q  <= acc_q[82:0];
        vph_pkg::OP_DV_Y:  dv_q  <= dv_q + acc_q[82:0];
        vph_pkg::OP_TDU:   tdu_q <= acc_q[48:0];
        vph_pkg::OP_RHS:   rhs_q <= acc_q[131:0];
        vph_pkg::OP_LHS:   lhs_q <= {acc_q[119:0], 16'h0000};
        vph_pkg::OP_P1:    p1_q  <= acc_q[79:0];
        vph_pkg::OP_P2:    p2_q  <= acc_q[79:0];
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      inlier_o   <= inl;
      score_o    <= score_new;
      last_out_o <= last_q;
    end
  end

endmodule

// File: hw/rtl/vanishing_point_hypothesis_scorer.sv
// Top level of the vanishing-point hypothesis scorer: sequencer plus datapath.
// Depends on vph_pkg, vph_seg_if, vph_res_if, vph_ctrl and vph_datapath.
//
//   Channel   Direction  Transaction contents
//   seg_i     in         start/end point, seg_length, live, last_in
//   res_o     out        inlier, score, last_out
//   cfg_*     in         write of one of five hypothesis registers (no read)
//
// Each segment passes from acceptance to its result through a capture step,
// the chunk steps of the shared 84x16 multiplier, a store step per product
// and a decision step. The next segment is accepted in the cycle after the
// decision, not earlier, so segments are taken one at a time.
// Reset is asynchronous and active low; it clears the configuration, the
// score and the handshake state. The result register holds a finished
// transaction while res_o stalls, and a new segment may be accepted and
// processed meanwhile; the sequencer only waits at the decision step while
// the result register is still full.
module vanishing_point_hypothesis_scorer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vph_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [vph_pkg::CfgDataW-1:0]  cfg_data_i,
  vph_seg_if.sink                       seg_i,
  vph_res_if.source                     res_o
);

  vph_pkg::ctrl_cmd_t cmd;

  // The sequencer owns both handshakes; the datapath owns all payload.
  vph_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (seg_i.valid),
    .in_ready_o  (seg_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd)
  );

  vph_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .start_x_i    (seg_i.start_x),
    .start_y_i    (seg_i.start_y),
    .end_x_i      (seg_i.end_x),
    .end_y_i      (seg_i.end_y),
    .seg_length_i (seg_i.seg_length),
    .live_i       (seg_i.live),
    .last_in_i    (seg_i.last_in),
    .inlier_o     (res_o.inlier),
    .score_o      (res_o.score),
    .last_out_o   (res_o.last_out)
  );

endmodule

// File: tb/sv/tb_vph_score_book.sv
// Scoreboard for the vanishing-point hypothesis scorer: predicts each segment's result.
// Depends on vph_pkg; used by tb_vanishing_point_hypothesis_scorer.
class vph_score_book;

  logic signed [23:0] vp_x, vp_y, vp_w;
  logic        [15:0] cos_thr, min_len;
  logic        [31:0] score_sum;
  logic               pend_inlier[$];
  logic        [31:0] pend_score[$];
  logic               pend_last[$];
  int unsigned        err_count;

  function void clear();
    vp_x = '0;
    vp_y = '0;
    vp_w = '0;
    cos_thr = '0;
    min_len = '0;
    score_sum = '0;
    err_count = 0;
  endfunction

  function void set_reg(logic [vph_pkg::CfgIdxW-1:0] idx, logic [23:0] val);
    case (idx)
      vph_pkg::CFG_VP_X:    vp_x = val;
      vph_pkg::CFG_VP_Y:    vp_y = val;
      vph_pkg::CFG_VP_W:    vp_w = val;
      vph_pkg::CFG_COS_THR: cos_thr = val[15:0];
      vph_pkg::CFG_MIN_LEN: min_len = val[15:0];
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return pend_score.size();
  endfunction

  // Squared cosine strictly above the threshold, by cross-multiplication.
  function bit cosine_passes(longint sx, longint sy, longint ex, longint ey);
    longint       dx, dy, vx, vy, dot;
    logic [191:0] lhs, rhs, du, dv, adot, avx, avy;
    dx = sx - ex;
    dy = sy - ey;
    vx = (sx + ex) * longint'(vp_w) - 2 * longint'(vp_x);
    vy = (sy + ey) * longint'(vp_w) - 2 * longint'(vp_y);
    dot = dx * vx + dy * vy;
    adot = (dot < 0) ? -dot : dot;
    avx = (vx < 0) ? -vx : vx;
    avy = (vy < 0) ? -vy : vy;
    du = dx * dx + dy * dy;
    dv = avx * avx + avy * avy;
    lhs = adot * adot * 192'd65536;
    rhs = 192'(cos_thr) * du * dv;
    return lhs > rhs;
  endfunction

  // Point strictly between the endpoints, all terms scaled by w squared.
  function bit point_between(longint sx, longint sy, longint ex, longint ey);
    longint       a, b, c, d;
    logic [191:0] pa, pb, neg_sum, pos_sum;
    if (vp_w == 0) return 1'b0;
    a = sx * longint'(vp_w) - longint'(vp_x);
    b = ex * longint'(vp_w) - longint'(vp_x);
    c = sy * longint'(vp_w) - longint'(vp_y);
    d = ey * longint'(vp_w) - longint'(vp_y);
    pa = 192'((a < 0) ? -a : a) * 192'((b < 0) ? -b : b);
    pb = 192'((c < 0) ? -c : c) * 192'((d < 0) ? -d : d);
    neg_sum = '0;
    pos_sum = '0;
    if ((a < 0) != (b < 0)) neg_sum += pa; else pos_sum += pa;
    if ((c < 0) != (d < 0)) neg_sum += pb; else pos_sum += pb;
    return neg_sum > pos_sum;
  endfunction

  function void note_segment(logic signed [15:0] sx, logic signed [15:0] sy,
                             logic signed [15:0] ex, logic signed [15:0] ey,
                             logic [15:0] len, logic live, logic last);
    bit          inl;
    logic [32:0] sum;
    inl = live && (len >= min_len) && cosine_passes(sx, sy, ex, ey) &&
          !point_between(sx, sy, ex, ey);
    if (inl) begin
      sum = {1'b0, score_sum} + 33'(len);
      score_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
    pend_inlier = {pend_inlier, inl};
    pend_score = {pend_score, score_sum};
    pend_last = {pend_last, last};
    if (last) score_sum = '0;
  endfunction

  function void check_result(logic inlier, logic [31:0] score, logic last);
    logic        e_inl, e_last;
    logic [31:0] e_score;
    if (pend_score.size() == 0) begin
      $error("unexpected result transaction: inlier %0d score %0d", inlier, score);
      err_count++;
      return;
    end
    e_inl = pend_inlier.pop_front();
    e_score = pend_score.pop_front();
    e_last = pend_last.pop_front();
    if (inlier !== e_inl) begin
      $error("inlier: expected %0d, actual %0d", e_inl, inlier);
      err_count++;
    end
    if (score !== e_score) begin
      $error("score: expected %0d, actual %0d", e_score, score);
      err_count++;
    end
    if (last !== e_last) begin
      $error("last_out: expected %0d, actual %0d", e_last, last);
      err_count++;
    end
  endfunction

endclass

// File: tb/sv/tb_vanishing_point_hypothesis_scorer.sv
// Testbench top for the vanishing-point hypothesis scorer: directed and random segments.
// Depends on vph_pkg, vph_seg_if, vph_res_if, the scorer RTL and tb_vph_score_book.sv.
module tb_vanishing_point_hypothesis_scorer;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CfgIdxW  = vph_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = vph_pkg::CfgDataW;

  // Long gaps on both sides can slow each segment down, but this cap stays far
  // above a correct run.
  localparam int unsigned CycleLimit = 5_000_000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int unsigned         cycle_count = 0;
  int unsigned         res_hold = 0;
  bit                  stim_done = 1'b0;

  vph_seg_if seg_ch ();
  vph_res_if res_ch ();

  vph_score_book book = new();

  vanishing_point_hypothesis_scorer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .seg_i      (seg_ch.sink),
    .res_o      (res_ch.source)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    seg_ch.valid = 1'b0;
    seg_ch.start_x = '0;
    seg_ch.start_y = '0;
    seg_ch.end_x = '0;
    seg_ch.end_y = '0;
    seg_ch.seg_length = '0;
    seg_ch.live = 1'b0;
    seg_ch.last_in = 1'b0;
    res_ch.ready = 1'b0;
  end

  // Mostly short gaps, now and then a long one, and often none at all.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // The result side stalls at random, sometimes for a long stretch; every
  // transaction goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        book.check_result(res_ch.inlier, res_ch.score, res_ch.last_out);
      end
      if (res_hold != 0) begin
        res_hold <= res_hold - 1;
        res_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 70) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b0;
        res_hold <= gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic wait_cycles(int unsigned n);
    repeat (n) @(posedge clk_i);
  endtask

  // Write one register; the scoreboard copy is updated at the same edge.
  // The enable drops for one cycle so that back-to-back writes never drive it
  // twice in one time step.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    book.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain every expected result, then let the pipeline settle before a write.
  task automatic drain();
    while (book.pending() != 0) @(posedge clk_i);
    wait_cycles(70);
  endtask

  task automatic set_hypothesis(logic [23:0] px, logic [23:0] py, logic [23:0] pw,
                                logic [15:0] thr, logic [15:0] mlen);
    drain();
    write_reg(vph_pkg::CFG_VP_X, px);
    write_reg(vph_pkg::CFG_VP_Y, py);
    write_reg(vph_pkg::CFG_VP_W, pw);
    write_reg(vph_pkg::CFG_COS_THR, {8'd0, thr});
    write_reg(vph_pkg::CFG_MIN_LEN, {8'd0, mlen});
  endtask

  // Offer one segment and hold it until the transaction completes. Valid stays
  // low for at least one cycle afterwards, so it is never driven twice in one
  // time step.
  task automatic send_seg(logic [15:0] sx, logic [15:0] sy, logic [15:0] ex,
                          logic [15:0] ey, logic [15:0] len, logic live, logic last);
    seg_ch.valid <= 1'b1;
    seg_ch.start_x <= sx;
    seg_ch.start_y <= sy;
    seg_ch.end_x <= ex;
    seg_ch.end_y <= ey;
    seg_ch.seg_length <= len;
    seg_ch.live <= live;
    seg_ch.last_in <= last;
    @(posedge clk_i);
    while (!seg_ch.ready) @(posedge clk_i);
    book.note_segment(sx, sy, ex, ey, len, live, last);
    seg_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait_cycles(gap_len());
  endtask

  // Random segment roughly along a ray from the origin so that inliers and the
  // between-endpoints case both show up; every so often wild values.
  task automatic random_seg(logic last);
    logic [15:0] sx, sy, ex, ey, len;
    int          cx, cy;
    if ($urandom_range(0, 3) == 0) begin
      sx = 16'($urandom);
      sy = 16'($urandom);
      ex = 16'($urandom);
      ey = 16'($urandom);
    end else begin
      cx = $urandom_range(0, 4000) - 2000;
      cy = $urandom_range(0, 4000) - 2000;
      sx = 16'(cx);
      sy = 16'(cy);
      ex = 16'(cx * $urandom_range(2, 6) / 2 + $urandom_range(0, 20) - 10);
      ey = 16'(cy * $urandom_range(2, 6) / 2 + $urandom_range(0, 20) - 10);
    end
    len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
    send_seg(sx, sy, ex, ey, len, ($urandom_range(0, 9) != 0), last);
  endtask

  initial begin
    int unsigned n_items;
    int unsigned run_len;
    wait_cycles(11);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    book.clear();

    // Directed: the point at the origin with w = 1 and a loose threshold.
    set_hypothesis(24'd0, 24'd0, 24'd1, 16'd32768, 16'd16);
    // Radial segment pointing at the origin, an inlier.
    send_seg(16'd100, 16'd100, 16'd200, 16'd200, 16'd50, 1'b1, 1'b0);
    // Dead segment.
    send_seg(16'd100, 16'd100, 16'd200, 16'd200, 16'd50, 1'b0, 1'b0);
    // Shorter than the minimum length.
    send_seg(16'd100, 16'd100, 16'd200, 16'd200, 16'd15, 1'b1, 1'b0);
    // Zero-length direction.
    send_seg(16'd300, 16'd300, 16'd300, 16'd300, 16'd50, 1'b1, 1'b0);
    // Point strictly between the endpoints.
    send_seg(-16'sd100, -16'sd100, 16'd100, 16'd100, 16'd50, 1'b1, 1'b0);
    // Point on an endpoint.
    send_seg(16'd0, 16'd0, 16'd100, 16'd100, 16'd50, 1'b1, 1'b0);
    // Perpendicular segment, fails the cosine test.
    send_seg(16'd100, -16'sd100, -16'sd90, 16'd110, 16'd50, 1'b1, 1'b0);
    // Field extremes, then the end of the pass.
    send_seg(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b1, 1'b0);
    send_seg(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, 1'b1);

    // All-zero point: the direction to it vanishes.
    set_hypothesis(24'd0, 24'd0, 24'd0, 16'd0, 16'd0);
    send_seg(16'd10, 16'd20, 16'd30, 16'd40, 16'd5, 1'b1, 1'b1);

    // Point at infinity along x with an extreme threshold and minimum length.
    set_hypothesis(24'd1, 24'd0, 24'd0, 16'hFFFF, 16'hFFFF);
    send_seg(16'd0, 16'd5, 16'd1000, 16'd5, 16'hFFFF, 1'b1, 1'b0);
    send_seg(16'd0, 16'd5, 16'd1000, 16'd5, 16'hFFFE, 1'b1, 1'b1);

    // Register extremes with the point off the midpoint on the same line.
    set_hypothesis(24'h7FFFFF, 24'h800000, 24'h800000, 16'd1, 16'd0);
    send_seg(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'd7, 1'b1, 1'b0);
    send_seg(16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'd7, 1'b1, 1'b1);

    // Running score over a pass of full-length segments: threshold 0 accepts any aligned segment.
    set_hypothesis(24'd0, 24'd0, 24'd0, 16'd0, 16'd0);
    write_reg(vph_pkg::CFG_VP_X, 24'd1);
    write_reg(vph_pkg::CFG_MIN_LEN, 24'd0);
    for (int i = 0; i < 6; i++) begin
      send_seg(16'd0, 16'd0, 16'd100, 16'd0, 16'hFFFF, 1'b1, 1'b0);
    end
    send_seg(16'd0, 16'd0, 16'd100, 16'd0, 16'hFFFF, 1'b1, 1'b1);

    // Random phases: each picks a new hypothesis, then runs passes of segments.
    n_items = 0;
    while (n_items < 1100) begin
      case ($urandom_range(0, 3))
        0: set_hypothesis(24'($urandom), 24'($urandom), 24'd0, 16'($urandom),
                          16'($urandom_range(0, 300)));
        1: set_hypothesis(24'($urandom_range(0, 4000)) - 24'd2000,
                          24'($urandom_range(0, 4000)) - 24'd2000, 24'd1,
                          16'($urandom_range(40000, 65535)), 16'($urandom_range(0, 300)));
        2: set_hypothesis(24'($urandom), 24'($urandom), 24'($urandom), 16'($urandom),
                          16'($urandom));
        default: set_hypothesis(24'($urandom_range(0, 1000)), 24'($urandom_range(0, 1000)),
                                24'($urandom_range(1, 3)), 16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 100)));
      endcase
      // Exercise the ignored register indexes too.
      write_reg(CfgIdxW'($urandom_range(5, 7)), CfgDataW'($urandom));
      for (int p = 0; p < 8; p++) begin
        run_len = $urandom_range(1, 30);
        for (int k = 0; k < run_len; k++) begin
          random_seg(k == run_len - 1);
          n_items++;
        end
      end
      // Hold off the sender until everything in flight is out.
      while (book.pending() != 0) @(posedge clk_i);
    end

    while (book.pending() != 0) @(posedge clk_i);
    wait_cycles(100);
    if (book.err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: vanishing_point_hypothesis_scorer.f
hw/rtl/vph_pkg.sv
hw/rtl/vph_seg_if.sv
hw/rtl/vph_res_if.sv
hw/rtl/vph_ctrl.sv
hw/rtl/vph_datapath.sv
hw/rtl/vanishing_point_hypothesis_scorer.sv
tb/sv/tb_vph_score_book.sv
tb/sv/tb_vanishing_point_hypothesis_scorer.sv
